// ----- rtl/fgcf_pkg.sv -----
// ----------------------------------------------------------------------------
// fgcf_pkg
// Shared types and constants of the functional graph cycle finder.
// ----------------------------------------------------------------------------
package fgcf_pkg;

    // Table geometry
    localparam int CELLS  = 4096;
    localparam int CELL_W = $clog2(CELLS);
    localparam int CNT_W  = CELL_W + 1;

    // Item kinds
    localparam logic [1:0] KIND_LOAD = 2'd0;
    localparam logic [1:0] KIND_WALK = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;

    typedef logic [CELL_W-1:0] t_cell;
    typedef logic [CNT_W-1:0]  t_cnt;

    // Input item
    typedef struct packed {
        logic [1:0] kind;
        t_cell      cell_req;
        t_cell      successor;
        logic       alive_in;
    } t_in_item;

    // Result item
    typedef struct packed {
        logic  found_cycle;
        t_cell cycle_entry;
        t_cnt  cycle_length;
        t_cnt  trail_length;
        logic  read_alive;
        logic  read_labeled;
        t_cell read_label;
    } t_out_item;

    // One word of the cell table
    typedef struct packed {
        t_cell succ;      // successor index
        logic  alive;     // cell alive
        logic  lvalid;    // cycle label present
        t_cell label;     // cycle label (walk start)
        t_cell pos;       // trail position in the walk that labeled it
        logic  on_trail;  // on the trail of the walk in progress
    } t_entry;

endpackage

// ----- rtl/fgcf_in_if.sv -----
// ----------------------------------------------------------------------------
// fgcf_in_if
// Valid/ready channel carrying input items.
// ----------------------------------------------------------------------------
interface fgcf_in_if;
    import fgcf_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/fgcf_out_if.sv -----
// ----------------------------------------------------------------------------
// fgcf_out_if
// Valid/ready channel carrying result items.
// ----------------------------------------------------------------------------
interface fgcf_out_if;
    import fgcf_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/functional_graph_cycle_finder_unit.sv -----
// ----------------------------------------------------------------------------
// functional_graph_cycle_finder_unit
// Cycle finder over a table of cells, each with a successor, alive bit, label.
// ----------------------------------------------------------------------------
// After reset the block sweeps the cell table (one entry per cycle) and
// takes no item until that pass ends. Then one item is processed at a
// time; the next item is taken while a result waits in the output
// register. A load or an unknown kind goes from the accept straight to
// the done state; a read passes through the read state first. A walk
// is made of the accept, the steps following successors (the last one
// sees the stop cell), the steps walking the trail again to kill the
// cells off the found cycle, and a step to load the output register.
// The steps are bound by the single read port of the cell table and its
// registered read data; a write to the entry read in the same cycle is
// forwarded. A full output register that is not drained holds the block
// in its done state.
// ----------------------------------------------------------------------------
module functional_graph_cycle_finder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fgcf_in_if.sink    i_in,
    fgcf_out_if.source o_out
);
    import fgcf_pkg::*;

    // state codes
    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_WALK  = 3'd3;
    localparam logic [2:0] S_KILL  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam t_cnt CELLS_CNT = CNT_W'(CELLS);

    logic [2:0] r_state, n_state;
    t_cell      r_clr_addr, n_clr_addr;
    t_cell      r_start, n_start;
    t_cell      r_cur, n_cur;
    t_cell      r_entry, n_entry;
    t_cnt       r_count, n_count;
    t_cnt       r_idx, n_idx;
    t_cell      r_p, n_p;
    logic       r_cycle, n_cycle;
    t_out_item  r_res, n_res;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out_data, n_out_data;
    logic       r_fwd_hit;
    t_entry     r_fwd_data;

    logic       we;
    t_cell      waddr;
    t_entry     wdata;
    t_cell      raddr;
    t_entry     mem_rdata;
    t_entry     rd;
    logic       accept;
    logic       slot_free;
    logic       walk_go;

    fgcf_mem u_mem (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (mem_rdata)
    );

    // forward a write that hit the address read in the same cycle
    always_ff @(posedge i_clk) begin
        r_fwd_hit  <= we && (waddr == raddr);
        r_fwd_data <= wdata;
    end

    assign rd = r_fwd_hit ? r_fwd_data : mem_rdata;

    // handshakes
    assign i_in.ready  = (r_state == S_IDLE);
    assign accept      = i_in.valid && i_in.ready;
    assign slot_free   = !r_out_valid || o_out.ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

    // a walk step continues on a live, unlabeled cell
    assign walk_go = rd.alive && !rd.lvalid && (r_count < CELLS_CNT);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_start     = r_start;
        n_cur       = r_cur;
        n_entry     = r_entry;
        n_count     = r_count;
        n_idx       = r_idx;
        n_p         = r_p;
        n_cycle     = r_cycle;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        we          = 1'b0;
        waddr       = r_cur;
        wdata       = rd;
        raddr       = r_cur;

        // output register drains independently
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                we         = 1'b1;
                waddr      = r_clr_addr;
                wdata      = '0;
                n_clr_addr = r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                raddr = i_in.data.cell_req;
                if (accept) begin
                    n_res   = '0;
                    n_start = i_in.data.cell_req;
                    n_cur   = i_in.data.cell_req;
                    n_count = '0;
                    n_cycle = 1'b0;
                    case (i_in.data.kind)
                        KIND_LOAD: begin
                            we          = 1'b1;
                            waddr       = i_in.data.cell_req;
                            wdata       = '0;
                            wdata.succ  = i_in.data.successor;
                            wdata.alive = i_in.data.alive_in;
                            n_state     = S_DONE;
                        end
                        KIND_WALK: n_state = S_WALK;
                        KIND_READ: n_state = S_READ;
                        default:   n_state = S_DONE;
                    endcase
                end
            end
            S_READ: begin
                n_res.read_alive   = rd.alive;
                n_res.read_labeled = rd.lvalid;
                n_res.read_label   = rd.lvalid ? rd.label : '0;
                n_state            = S_DONE;
            end
            S_WALK: begin
                if (walk_go) begin
                    // label the cell and step to its successor
                    we             = 1'b1;
                    wdata.lvalid   = 1'b1;
                    wdata.label    = r_start;
                    wdata.pos      = r_count[CELL_W-1:0];
                    wdata.on_trail = 1'b1;
                    raddr          = rd.succ;
                    n_cur          = rd.succ;
                    n_count        = r_count + 1'b1;
                end else begin
                    // stopped: a cycle is found if the stop cell is on this trail
                    n_cycle = (r_count != '0) && rd.on_trail;
                    n_p     = rd.pos;
                    n_entry = r_cur;
                    n_idx   = '0;
                    raddr   = r_start;
                    n_cur   = r_start;
                    n_res.trail_length = r_count;
                    if (r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_KILL;
                    end
                end
            end
            S_KILL: begin
                // second pass: drop trail marks, kill lead-in or whole trail
                we             = 1'b1;
                wdata.on_trail = 1'b0;
                wdata.alive    = r_cycle && (r_idx >= {1'b0, r_p});
                raddr          = rd.succ;
                n_cur          = rd.succ;
                n_idx          = r_idx + 1'b1;
                if (r_idx == r_count - 1'b1) begin
                    n_res.found_cycle  = r_cycle;
                    n_res.cycle_entry  = r_cycle ? r_entry : '0;
                    n_res.cycle_length = r_cycle ? (r_count - {1'b0, r_p}) : '0;
                    n_state            = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_res;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // walk and result registers
    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_cur      <= n_cur;
        r_entry    <= n_entry;
        r_count    <= n_count;
        r_idx      <= n_idx;
        r_p        <= n_p;
        r_cycle    <= n_cycle;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

endmodule

// ----- rtl/fgcf_mem.sv -----
// ----------------------------------------------------------------------------
// fgcf_mem
// Cell table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fgcf_mem (
    input  logic             i_clk,
    input  logic             i_we,
    input  fgcf_pkg::t_cell  i_waddr,
    input  fgcf_pkg::t_entry i_wdata,
    input  fgcf_pkg::t_cell  i_raddr,
    output fgcf_pkg::t_entry o_rdata
);
    import fgcf_pkg::*;

    t_entry mem [CELLS];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // read port, old data on a same-address collision
    always_ff @(posedge i_clk) begin
        o_rdata <= mem[i_raddr];
    end

endmodule
